// ===== src/rolling_kmer_hash_sampler_defines.svh =====
// assertion macros shared by the rolling k-mer hash sampler rtl
// no dependencies; included by the modules that carry checks
`ifndef ROLLING_KMER_HASH_SAMPLER_DEFINES_SVH
`define ROLLING_KMER_HASH_SAMPLER_DEFINES_SVH

`ifndef SYNTHESIS

`define RKH_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rolling kmer hash sampler check failed");

`define RKH_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rolling kmer hash sampler check failed");

`else

`define RKH_ASSERT_IMP(lbl, ck, rn, ante, cons)

`define RKH_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ===== src/rkh_pkg.sv =====
// types, constants and helper functions of the rolling k-mer hash sampler
// no dependencies
`default_nettype none

package rkh_pkg;

  localparam int SEQ_W      = 8;
  localparam int HASH_W     = 32;
  localparam int IDX_W      = 11;
  localparam int KLEN_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KMER_LENGTH = 3'd0,
    REG_SAMPLE_THR  = 3'd1,
    REG_MIX_SEED    = 3'd2,
    REG_REJECT_LC   = 3'd3,
    REG_MULT_ONE    = 3'd4,
    REG_MULT_TWO    = 3'd5
  } reg_idx_t;

  localparam logic [KLEN_W-1:0] RST_KMER_LENGTH = 7'd17;
  localparam logic [31:0]       RST_SAMPLE_THR  = 32'h0FFF_FFFF;
  localparam logic [63:0]       RST_MIX_SEED    = 64'd42;
  localparam logic [63:0]       RST_MULT_ONE    = 64'hFF51_AFD7_ED55_8CCD;
  localparam logic [63:0]       RST_MULT_TWO    = 64'hC4CE_B9FE_1A85_EC53;

  localparam logic [63:0] SEED_TABLE [4] = '{
    64'h3c8b_f4f5_3c8b_f4f5,
    64'h04c9_03a7_04c9_03a7,
    64'h2b81_04c9_2b81_04c9,
    64'h2e06_00d3_fd09_e083
  };

  localparam logic [SEQ_W-1:0] CH_UP_A = 8'h41;
  localparam logic [SEQ_W-1:0] CH_UP_C = 8'h43;
  localparam logic [SEQ_W-1:0] CH_UP_G = 8'h47;
  localparam logic [SEQ_W-1:0] CH_UP_T = 8'h54;
  localparam logic [SEQ_W-1:0] CH_LO_A = 8'h61;
  localparam logic [SEQ_W-1:0] CH_LO_C = 8'h63;
  localparam logic [SEQ_W-1:0] CH_LO_G = 8'h67;
  localparam logic [SEQ_W-1:0] CH_LO_T = 8'h74;

  typedef struct packed {
    logic [KLEN_W-1:0] kmer_length;
    logic [31:0]       sample_threshold;
    logic [63:0]       mix_seed;
    logic              reject_lowercase;
    logic [63:0]       mult_one;
    logic [63:0]       mult_two;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_LL = 2'd0,
    MUL_LH = 2'd1,
    MUL_HL = 2'd2
  } mul_part_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_ROLL   = 3'd1,
    ST_CANON  = 3'd2,
    ST_MUL_LL = 3'd3,
    ST_MUL_LH = 3'd4,
    ST_MUL_HL = 3'd5,
    ST_XS     = 3'd6,
    ST_FIN    = 3'd7
  } state_t;

  typedef struct packed {
    logic      load;
    logic      roll;
    logic      canon;
    logic      mul_en;
    mul_part_t part;
    logic      mul_second;
    logic      xs;
    logic      fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic kmer_ok;
    logic out_blocked;
  } dp_status_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } base_t;

  function automatic base_t base_decode(input logic [SEQ_W-1:0] ch, input logic reject_lc);
    base_t d;
    d.valid = 1'b1;
    d.code  = 2'd0;
    unique case (ch)
      CH_UP_A: d.code = 2'd0;
      CH_UP_C: d.code = 2'd1;
      CH_UP_G: d.code = 2'd2;
      CH_UP_T: d.code = 2'd3;
      CH_LO_A: begin d.code = 2'd0; d.valid = !reject_lc; end
      CH_LO_C: begin d.code = 2'd1; d.valid = !reject_lc; end
      CH_LO_G: begin d.code = 2'd2; d.valid = !reject_lc; end
      CH_LO_T: begin d.code = 2'd3; d.valid = !reject_lc; end
      default: d.valid = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] amt);
    logic [127:0] d;
    d = {v, v} << amt;
    return d[127:64];
  endfunction

endpackage

`default_nettype wire

// ===== src/rkh_stream_if.sv =====
// request and result channel interfaces of the rolling k-mer hash sampler
// depends on rkh_pkg
`default_nettype none

interface rkh_in_if import rkh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seq_byte;
  logic             window_start;

  modport source (output valid, seq_byte, window_start, input ready);
  modport sink   (input valid, seq_byte, window_start, output ready);
endinterface

interface rkh_out_if import rkh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] sampled_hash;
  logic [IDX_W-1:0]  sample_index;

  modport source (output valid, sampled_hash, sample_index, input ready);
  modport sink   (input valid, sampled_hash, sample_index, output ready);
endinterface

`default_nettype wire

// ===== src/rkh_cfg_regs.sv =====
// configuration register bank with write-only port
// depends on rkh_pkg
`default_nettype none

module rkh_cfg_regs import rkh_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_KMER_LENGTH: cfg_nxt.kmer_length      = cfg_wdata[KLEN_W-1:0];
        REG_SAMPLE_THR:  cfg_nxt.sample_threshold = cfg_wdata[31:0];
        REG_MIX_SEED:    cfg_nxt.mix_seed         = cfg_wdata;
        REG_REJECT_LC:   cfg_nxt.reject_lowercase = cfg_wdata[0];
        REG_MULT_ONE:    cfg_nxt.mult_one         = cfg_wdata;
        REG_MULT_TWO:    cfg_nxt.mult_two         = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kmer_length      <= RST_KMER_LENGTH;
      cfg_r.sample_threshold <= RST_SAMPLE_THR;
      cfg_r.mix_seed         <= RST_MIX_SEED;
      cfg_r.reject_lowercase <= 1'b0;
      cfg_r.mult_one         <= RST_MULT_ONE;
      cfg_r.mult_two         <= RST_MULT_TWO;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== src/rkh_ctrl.sv =====
// controller state machine: sequences roll, canonical mix and two multiplies
// depends on rkh_pkg and rolling_kmer_hash_sampler_defines.svh
`default_nettype none
`include "rolling_kmer_hash_sampler_defines.svh"

module rkh_ctrl import rkh_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   pass2_r;
  logic   pass2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass2_r <= pass2_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    pass2_nxt      = pass2_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.part       = MUL_LL;
    cmd.mul_second = pass2_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ROLL;
        end
      end
      ST_ROLL: begin
        cmd.roll  = 1'b1;
        state_nxt = status.kmer_ok ? ST_CANON : ST_IDLE;
      end
      ST_CANON: begin
        cmd.canon = 1'b1;
        pass2_nxt = 1'b0;
        state_nxt = ST_MUL_LL;
      end
      ST_MUL_LL: begin
        cmd.mul_en = 1'b1;
        cmd.part   = MUL_LL;
        state_nxt  = ST_MUL_LH;
      end
      ST_MUL_LH: begin
        cmd.mul_en = 1'b1;
        cmd.part   = MUL_LH;
        state_nxt  = ST_MUL_HL;
      end
      ST_MUL_HL: begin
        cmd.mul_en = 1'b1;
        cmd.part   = MUL_HL;
        state_nxt  = pass2_r ? ST_FIN : ST_XS;
      end
      ST_XS: begin
        cmd.xs    = 1'b1;
        pass2_nxt = 1'b1;
        state_nxt = ST_MUL_LL;
      end
      ST_FIN: begin
        if (!status.out_blocked) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `RKH_ASSERT_NXT(a_load_then_roll, clk, rst_n, cmd.load, state_r == ST_ROLL)
  `RKH_ASSERT_IMP(a_fin_after_two_mults, clk, rst_n, state_r == ST_FIN, pass2_r)
  `RKH_ASSERT_NXT(a_xs_starts_second, clk, rst_n, state_r == ST_XS, state_r == ST_MUL_LL && pass2_r)

endmodule

`default_nettype wire

// ===== src/rkh_datapath.sv =====
// datapath: rolling hashes, base history memory, finalizer and output register
// depends on rkh_pkg
`default_nettype none

module rkh_datapath import rkh_pkg::*; #(
  parameter int MAX_KMER = 64,
  parameter int MAX_KEPT = 2048
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire ctrl_cmd_t         cmd,
  output dp_status_t             status,
  input  wire logic [SEQ_W-1:0]  in_seq_byte,
  input  wire logic              in_window_start,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [HASH_W-1:0]      out_sampled_hash,
  output logic [IDX_W-1:0]       out_sample_index
);

  localparam int HW    = (MAX_KMER > 1) ? $clog2(MAX_KMER) : 1;
  localparam int DEPTH = 1 << HW;
  localparam int KW    = $clog2(MAX_KEPT + 1);
  localparam logic [KLEN_W-1:0] K_MAX    = KLEN_W'(MAX_KMER);
  localparam logic [KW-1:0]     KEPT_MAX = KW'(MAX_KEPT);

  logic [1:0] hist_mem [DEPTH];

  logic [SEQ_W-1:0]  byte_r;
  logic              ws_r;
  logic [63:0]       fwd_r, fwd_nxt;
  logic [63:0]       rev_r, rev_nxt;
  logic [KLEN_W-1:0] run_r, run_nxt;
  logic [KW-1:0]     kept_r, kept_nxt;
  logic [HW-1:0]     wp_r, wp_nxt;
  logic [63:0]       x_r, x_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [1:0]        hist_rd_r;
  logic              out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0] out_hash_r;
  logic [IDX_W-1:0]  out_idx_r;

  logic [KLEN_W-1:0] k_eff;
  logic [KLEN_W-1:0] k_m1;
  logic [KLEN_W-1:0] fill_amt;
  logic [HW-1:0]     rd_addr;
  base_t             dec;
  logic [1:0]        code_inv;
  logic [1:0]        gone;
  logic [63:0]       fwd0, rev0;
  logic [KLEN_W-1:0] run0, run_roll;
  logic [63:0]       canon, mixed_in;
  logic [63:0]       mult;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic [63:0]       fin_h;
  logic              pass;

  always_comb begin
    if (cfg.kmer_length == '0) begin
      k_eff = KLEN_W'(1);
    end else if (cfg.kmer_length > K_MAX) begin
      k_eff = K_MAX;
    end else begin
      k_eff = cfg.kmer_length;
    end
  end

  assign k_m1     = k_eff - KLEN_W'(1);
  assign rd_addr  = wp_r - k_eff[HW-1:0];
  assign dec      = base_decode(byte_r, cfg.reject_lowercase);
  assign code_inv = dec.code ^ 2'b11;
  assign gone     = hist_rd_r;
  assign fwd0     = ws_r ? '0 : fwd_r;
  assign rev0     = ws_r ? '0 : rev_r;
  assign run0     = ws_r ? '0 : run_r;
  assign fill_amt = k_m1 - run0;
  assign run_roll = (run0 < k_eff) ? run0 + KLEN_W'(1) : run0;

  assign status.kmer_ok     = dec.valid && (run_roll >= k_eff);
  assign status.out_blocked = out_valid_r && !out_ready;

  assign canon    = (fwd_r < rev_r) ? fwd_r : rev_r;
  assign mixed_in = canon ^ cfg.mix_seed;
  assign mult     = cmd.mul_second ? cfg.mult_two : cfg.mult_one;
  assign mul_a    = (cmd.part == MUL_HL) ? x_r[63:32] : x_r[31:0];
  assign mul_b    = (cmd.part == MUL_LH) ? mult[63:32] : mult[31:0];
  assign prod     = 64'(mul_a) * 64'(mul_b);
  assign fin_h    = acc_r ^ (acc_r >> 33);
  assign pass     = (fin_h[31:0] < cfg.sample_threshold) && (kept_r < KEPT_MAX);

  always_comb begin
    fwd_nxt       = fwd_r;
    rev_nxt       = rev_r;
    run_nxt       = run_r;
    kept_nxt      = kept_r;
    wp_nxt        = wp_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.roll) begin
      kept_nxt = ws_r ? '0 : kept_r;
      if (!dec.valid) begin
        fwd_nxt = '0;
        rev_nxt = '0;
        run_nxt = '0;
      end else begin
        wp_nxt  = wp_r + HW'(1);
        run_nxt = run_roll;
        if (run0 < k_eff) begin
          fwd_nxt = fwd0 ^ rotl64(SEED_TABLE[dec.code], fill_amt[5:0]);
          rev_nxt = rev0 ^ rotl64(SEED_TABLE[code_inv], run0[5:0]);
        end else begin
          fwd_nxt = {fwd0[62:0], fwd0[63]} ^ rotl64(SEED_TABLE[gone], k_eff[5:0])
                    ^ SEED_TABLE[dec.code];
          rev_nxt = {rev0[0], rev0[63:1]}
                    ^ {SEED_TABLE[gone ^ 2'b11][0], SEED_TABLE[gone ^ 2'b11][63:1]}
                    ^ rotl64(SEED_TABLE[code_inv], k_m1[5:0]);
        end
      end
    end
    if (cmd.canon) begin
      x_nxt = mixed_in ^ (mixed_in >> 33);
    end
    if (cmd.xs) begin
      x_nxt = fin_h;
    end
    if (cmd.mul_en) begin
      unique case (cmd.part)
        MUL_LL:  acc_nxt = prod;
        MUL_LH,
        MUL_HL:  acc_nxt = {acc_r[63:32] + prod[31:0], acc_r[31:0]};
        default: acc_nxt = acc_r;
      endcase
    end
    if (cmd.fin && pass) begin
      out_valid_nxt = 1'b1;
      kept_nxt      = kept_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r       <= '0;
      rev_r       <= '0;
      run_r       <= '0;
      kept_r      <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fwd_r       <= fwd_nxt;
      rev_r       <= rev_nxt;
      run_r       <= run_nxt;
      kept_r      <= kept_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_seq_byte;
      ws_r   <= in_window_start;
    end
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
    if (cmd.fin && pass) begin
      out_hash_r <= fin_h[31:0];
      out_idx_r  <= IDX_W'(kept_r);
    end
  end

  // base history ring, read k bases behind the write pointer
  always_ff @(posedge clk) begin
    if (cmd.roll && dec.valid) begin
      hist_mem[wp_r] <= dec.code;
    end
    hist_rd_r <= hist_mem[rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_sampled_hash = out_hash_r;
  assign out_sample_index = out_idx_r;

endmodule

`default_nettype wire

// ===== src/rolling_kmer_hash_sampler.sv =====
// flow: an accepted request goes through roll, canonical mix, multiply, xor-shift, multiply
//   and finish; without a complete k-mer it returns to idle after the roll; a new request is
//   taken only in idle; the shared 32x32 multiplier forms each 64-bit product in three parts
// reset: synchronous active-low rst_n clears hashes, run length, kept count and
//   output valid, and loads register defaults; the base history ring is not cleared
// depends on rkh_pkg, rkh_stream_if, rkh_cfg_regs, rkh_ctrl, rkh_datapath
`default_nettype none

module rolling_kmer_hash_sampler import rkh_pkg::*; #(
  parameter int MAX_KMER = 64,
  parameter int MAX_KEPT = 2048
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rkh_in_if.sink                     in_chan,
  rkh_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  rkh_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rkh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rkh_datapath #(
    .MAX_KMER (MAX_KMER),
    .MAX_KEPT (MAX_KEPT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .in_seq_byte      (in_chan.seq_byte),
    .in_window_start  (in_chan.window_start),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_sampled_hash (out_chan.sampled_hash),
    .out_sample_index (out_chan.sample_index)
  );

  assign in_chan.ready = in_ready;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking bench for rolling_kmer_hash_sampler: drives bytes, predicts sampled hashes
// depends on rkh_pkg, rkh_stream_if and the rolling_kmer_hash_sampler rtl
module tb_top import rkh_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KMER_MAX     = 64;
  localparam int KEPT_MAX     = 2048;
  localparam int DRAIN_CYCLES = 30;
  localparam int LIMIT_CYCLES = 600000;

  localparam logic [SEQ_W-1:0] BASE_CHARS [8] = '{
    CH_UP_A, CH_UP_C, CH_UP_G, CH_UP_T, CH_LO_A, CH_LO_C, CH_LO_G, CH_LO_T
  };
  localparam logic [SEQ_W-1:0] CH_N = 8'h4E;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_byte;
    logic             window_start;
  } kmer_req_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [IDX_W-1:0]  index;
  } hash_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             drv_valid = 1'b0;
  logic [SEQ_W-1:0] drv_byte = '0;
  logic             drv_ws = 1'b0;
  logic             out_rdy = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rkh_in_if  in_bus ();
  rkh_out_if out_bus ();

  assign in_bus.valid        = drv_valid;
  assign in_bus.seq_byte     = drv_byte;
  assign in_bus.window_start = drv_ws;
  assign out_bus.ready       = out_rdy;

  rolling_kmer_hash_sampler #(
    .MAX_KMER (KMER_MAX),
    .MAX_KEPT (KEPT_MAX)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus),
    .out_chan  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  kmer_req_t    req_pending [$];
  hash_sample_t sample_expect [$];
  kmer_req_t    cur_req;
  logic         req_taken = 1'b0;
  bit           calm = 1'b0;
  int           mismatches = 0;
  int           cycles = 0;

  logic [KLEN_W-1:0] k_cfg;
  logic [31:0]       thr_cfg;
  logic [63:0]       seed_cfg;
  logic              rej_cfg;
  logic [63:0]       mul1_cfg;
  logic [63:0]       mul2_cfg;

  logic [63:0] fwd_roll;
  logic [63:0] rev_roll;
  int          run_len;
  logic [1:0]  base_ring [KMER_MAX];
  int          kept_num;

  hash_sample_t want;
  hash_sample_t got;
  hash_sample_t pred;

  function automatic logic [63:0] rol64(input logic [63:0] v, input int n);
    int m;
    m = n & 63;
    return (v << m) | (v >> (64 - m));
  endfunction

  function automatic int base_of(input logic [SEQ_W-1:0] b, input logic rej);
    case (b)
      CH_UP_A: return 0;
      CH_UP_C: return 1;
      CH_UP_G: return 2;
      CH_UP_T: return 3;
      CH_LO_A: return rej ? -1 : 0;
      CH_LO_C: return rej ? -1 : 1;
      CH_LO_G: return rej ? -1 : 2;
      CH_LO_T: return rej ? -1 : 3;
      default: return -1;
    endcase
  endfunction

  function automatic bit predict_sample(input kmer_req_t r, output hash_sample_t s);
    int          k;
    int          code;
    int          gone;
    logic [63:0] canon;
    logic [63:0] h;
    s = '0;
    k = int'(k_cfg);
    if (k < 1) k = 1;
    if (k > KMER_MAX) k = KMER_MAX;
    if (r.window_start) begin
      fwd_roll = '0;
      rev_roll = '0;
      run_len  = 0;
      kept_num = 0;
    end
    code = base_of(r.seq_byte, rej_cfg);
    if (code < 0) begin
      fwd_roll = '0;
      rev_roll = '0;
      run_len  = 0;
      return 1'b0;
    end
    if (run_len < k) begin
      fwd_roll ^= rol64(SEED_TABLE[code], k - 1 - run_len);
      rev_roll ^= rol64(SEED_TABLE[code ^ 3], run_len);
      run_len++;
    end else begin
      gone = int'(base_ring[k - 1]);
      fwd_roll = rol64(fwd_roll, 1) ^ rol64(SEED_TABLE[gone], k) ^ SEED_TABLE[code];
      rev_roll = rol64(rev_roll, 63) ^ rol64(SEED_TABLE[gone ^ 3], 63) ^
                 rol64(SEED_TABLE[code ^ 3], k - 1);
    end
    for (int i = KMER_MAX - 1; i > 0; i--) base_ring[i] = base_ring[i - 1];
    base_ring[0] = code[1:0];
    if (run_len < k) return 1'b0;
    canon = (fwd_roll < rev_roll) ? fwd_roll : rev_roll;
    h = canon ^ seed_cfg;
    h ^= h >> 33;
    h = h * mul1_cfg;
    h ^= h >> 33;
    h = h * mul2_cfg;
    h ^= h >> 33;
    if (h[31:0] < thr_cfg && kept_num < KEPT_MAX) begin
      s.hash  = h[31:0];
      s.index = kept_num[IDX_W-1:0];
      kept_num++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("rolling_kmer_hash_sampler verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      k_cfg    = RST_KMER_LENGTH;
      thr_cfg  = RST_SAMPLE_THR;
      seed_cfg = RST_MIX_SEED;
      rej_cfg  = 1'b0;
      mul1_cfg = RST_MULT_ONE;
      mul2_cfg = RST_MULT_TWO;
      fwd_roll = '0;
      rev_roll = '0;
      run_len  = 0;
      kept_num = 0;
      req_taken = 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_KMER_LENGTH: k_cfg    = cfg_wdata[KLEN_W-1:0];
          REG_SAMPLE_THR:  thr_cfg  = cfg_wdata[31:0];
          REG_MIX_SEED:    seed_cfg = cfg_wdata;
          REG_REJECT_LC:   rej_cfg  = cfg_wdata[0];
          REG_MULT_ONE:    mul1_cfg = cfg_wdata;
          REG_MULT_TWO:    mul2_cfg = cfg_wdata;
          default: ;
        endcase
      end
      req_taken = drv_valid && in_bus.ready;
      if (req_taken) begin
        if (predict_sample(cur_req, pred)) sample_expect.push_back(pred);
      end
      if (out_bus.valid && out_rdy) begin
        got.hash  = out_bus.sampled_hash;
        got.index = out_bus.sample_index;
        if (sample_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected sample: hash %h index %0d", got.hash, got.index);
        end else begin
          want = sample_expect.pop_front();
          if (got.hash !== want.hash || got.index !== want.index) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample mismatch: expected hash %h index %0d, got hash %h index %0d",
                       want.hash, want.index, got.hash, got.index);
          end
        end
      end
    end
  end

  // request driver and result-side backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (!drv_valid || req_taken) begin
        if (req_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
          cur_req = req_pending.pop_front();
          drv_valid <= 1'b1;
          drv_byte  <= cur_req.seq_byte;
          drv_ws    <= cur_req.window_start;
        end else begin
          drv_valid <= 1'b0;
        end
      end
      out_rdy <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input logic [KLEN_W-1:0] k, input logic [31:0] thr,
                            input logic [63:0] seed, input logic rej,
                            input logic [63:0] m1, input logic [63:0] m2);
    write_reg(REG_KMER_LENGTH, CFG_DATA_W'(k));
    write_reg(REG_SAMPLE_THR, CFG_DATA_W'(thr));
    write_reg(REG_MIX_SEED, seed);
    write_reg(REG_REJECT_LC, CFG_DATA_W'(rej));
    write_reg(REG_MULT_ONE, m1);
    write_reg(REG_MULT_TWO, m2);
  endtask

  task automatic wait_idle();
    while (req_pending.size() != 0 || drv_valid || sample_expect.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_req(input logic [SEQ_W-1:0] b, input logic ws);
    kmer_req_t r;
    r.seq_byte     = b;
    r.window_start = ws;
    req_pending.push_back(r);
  endtask

  // mostly valid bases, noise_pct random bytes, ws_pct window starts;
  // sender holds off halfway until every sample is back
  task automatic random_phase(input int n, input int noise_pct, input int ws_pct,
                              input bit first_ws);
    logic [SEQ_W-1:0] b;
    logic             ws;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) b = SEQ_W'($urandom_range(0, 255));
      else b = BASE_CHARS[$urandom_range(0, 7)];
      ws = ($urandom_range(0, 99) < ws_pct) || (first_ws && i == 0);
      push_req(b, ws);
      if (i == n / 2) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every valid base yields a sample at k of one; invalid bytes yield none
    set_config(7'd1, 32'hFFFF_FFFF, 64'd0, 1'b0, RST_MULT_ONE, RST_MULT_TWO);
    push_req(CH_UP_A, 1'b1);
    push_req(CH_UP_C, 1'b0);
    push_req(CH_UP_G, 1'b0);
    push_req(CH_UP_T, 1'b0);
    push_req(CH_LO_A, 1'b0);
    push_req(CH_LO_C, 1'b0);
    push_req(CH_LO_G, 1'b0);
    push_req(CH_LO_T, 1'b0);
    push_req(8'h00, 1'b0);
    push_req(CH_UP_A, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(CH_N, 1'b0);
    push_req(8'h80, 1'b1);
    push_req(CH_UP_T, 1'b0);
    wait_idle();

    // lowercase rejected, k of two
    set_config(7'd2, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, RST_MULT_ONE,
               RST_MULT_TWO);
    push_req(CH_UP_A, 1'b1);
    push_req(CH_UP_C, 1'b0);
    push_req(CH_LO_A, 1'b0);
    push_req(CH_UP_G, 1'b0);
    push_req(CH_UP_T, 1'b0);
    push_req(CH_LO_C, 1'b0);
    push_req(CH_UP_T, 1'b0);
    push_req(CH_LO_G, 1'b0);
    push_req(CH_UP_A, 1'b0);
    push_req(CH_LO_T, 1'b0);
    wait_idle();

    set_config(RST_KMER_LENGTH, RST_SAMPLE_THR, RST_MIX_SEED, 1'b0, RST_MULT_ONE,
               RST_MULT_TWO);
    random_phase(100, 5, 2, 1'b1);

    set_config(7'd0, 32'hFFFF_FFFF, {$urandom, $urandom}, 1'b0, 64'd0,
               64'hFFFF_FFFF_FFFF_FFFF);
    random_phase(150, 15, 3, 1'b0);

    calm = 1'b1;
    set_config(7'd64, 32'h7FFF_FFFF, 64'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    random_phase(200, 1, 0, 1'b0);
    calm = 1'b0;

    set_config(7'd127, $urandom, {$urandom, $urandom}, 1'b1, {$urandom, $urandom},
               {$urandom, $urandom});
    random_phase(200, 1, 0, 1'b0);

    set_config(KLEN_W'($urandom_range(1, 63)), $urandom, {$urandom, $urandom},
               1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom});
    random_phase(200, 8, 2, 1'b0);

    set_config(7'd31, 32'd0, {$urandom, $urandom}, 1'b0, RST_MULT_ONE, RST_MULT_TWO);
    random_phase(150, 5, 2, 1'b0);

    set_config(7'd5, 32'hFFFF_FFFF, {$urandom, $urandom}, 1'b0, RST_MULT_ONE,
               RST_MULT_TWO);
    random_phase(200, 20, 5, 1'b0);

    // one long window, every base kept at k of one
    set_config(7'd1, 32'hFFFF_FFFF, {$urandom, $urandom}, 1'b0, RST_MULT_ONE,
               RST_MULT_TWO);
    random_phase(200, 1, 0, 1'b1);

    if (mismatches == 0) begin
      $display("rolling_kmer_hash_sampler verification clean");
    end else begin
      $display("rolling_kmer_hash_sampler verification failed");
    end
    $finish;
  end

endmodule
